FILE: hdl/psx_pkg.sv
// Shared types and constants for the per-station temperature extremes block.
package psx_pkg;

  // Default table depth, one entry per station
  localparam int unsigned STATIONS_DEFAULT = 1024;

  // Field widths
  localparam int unsigned SID_W  = 10;
  localparam int unsigned TEMP_W = 16;
  localparam int unsigned EXT_W  = 36;

  // Stream widths: input request and output result
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 88;
  localparam int unsigned S_PAD_W   = S_TDATA_W - SID_W - EXT_W;
  localparam int unsigned M_PAD_W   = M_TDATA_W - SID_W - 2 * EXT_W;

  // Request kinds carried on tuser
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // One extreme with its time stamp; temperature sits in the lowest bits
  typedef struct packed {
    logic [5:0]               minute;
    logic [4:0]               hour;
    logic [4:0]               day;
    logic [3:0]               month;
    logic signed [TEMP_W-1:0] temp;
  } extreme_t;

  // One table word: valid flag plus both extremes
  typedef struct packed {
    logic     valid;
    extreme_t high;
    extreme_t low;
  } entry_t;

  // Request as seen by the update logic
  typedef struct packed {
    logic     in_table;
    extreme_t sample;
  } request_t;

endpackage

FILE: hdl/per_station_temperature_extremes.sv
// Top level of the per-station temperature extremes tracker.
//
// Keeps the lowest and highest temperature, with month/day/hour/minute, for
// each of STATIONS stations in one synchronous RAM. A record request (tuser
// = 0) updates one station and gives no result; a read request (tuser = 1)
// gives one result with tuser = seen and all extremes zero for an unseen
// station or an id beyond the table. The block takes one request per clock:
// each request does one read-modify-write on the RAM port, and a one-entry
// write forward covers a request to the station written just before. A read
// request waits in the RAM stage while the output register holds a result
// that is not yet taken, and s_axis_tready stays low for that long.
// A taken read request passes the RAM read and then the output register
// before m_axis_tvalid rises.
// After reset the block sweeps every table entry to clear the seen flags;
// s_axis_tready stays low during that sweep.
module per_station_temperature_extremes
  import psx_pkg::*;
#(
  parameter int unsigned STATIONS = STATIONS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // station_id[9:0], sample_month[13:10], sample_day[18:14],
  // sample_hour[23:19], sample_minute[29:24], sample_temp[45:30], zeros[47:46]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // mode
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_station[9:0], low_temp[25:10], low_month[29:26], low_day[34:30],
  // low_hour[39:35], low_minute[45:40], high_temp[61:46], high_month[65:62],
  // high_day[70:66], high_hour[75:71], high_minute[81:76], zeros[87:82]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // seen
  output logic                 m_axis_tuser
);

  localparam int unsigned AW = $clog2(STATIONS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STATIONS - 1);

  // Clearing sweep
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // Stage 1: request waiting for its RAM data
  logic             p1_valid;
  logic             p1_mode;
  logic             p1_inside;
  logic [SID_W-1:0] p1_sid;
  logic [AW-1:0]    p1_addr;
  extreme_t         p1_sample;

  // Last write, for a request to the same station right behind it
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  entry_t        fwd_data;

  logic             out_free;
  logic             p1_done;
  logic             s_acc;
  logic             p1_write;
  logic [SID_W-1:0] in_sid;
  logic [AW-1:0]    in_addr;
  logic [AW-1:0]    rd_addr;
  entry_t           rd_data;
  entry_t           cur;
  entry_t           upd;
  entry_t           res;
  request_t         req;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  entry_t           wr_data;

  // Handshake
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign p1_done       = p1_valid && ((p1_mode == MODE_RECORD) || out_free);
  assign s_axis_tready = !clearing && (!p1_valid || p1_done);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign in_sid  = s_axis_tdata[SID_W-1:0];
  assign in_addr = AW'(in_sid);
  assign rd_addr = s_acc ? in_addr : p1_addr;

  // Pick forwarded data over the stale RAM word
  assign cur = (fwd_valid && (fwd_addr == p1_addr)) ? fwd_data : rd_data;

  assign req.in_table = p1_inside;
  assign req.sample   = p1_sample;

  psx_update u_update (
    .cur (cur),
    .req (req),
    .upd (upd),
    .res (res)
  );

  // RAM write: sweep first, then record requests
  assign p1_write = p1_done && (p1_mode == MODE_RECORD) && p1_inside;
  assign wr_en    = clearing || p1_write;
  assign wr_addr  = clearing ? clr_addr : p1_addr;
  assign wr_data  = clearing ? entry_t'('0) : upd;

  psx_mem #(
    .DEPTH (STATIONS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Advance the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  // Load stage 1 on each taken request
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (s_acc) begin
      p1_valid <= 1'b1;
    end else if (p1_done) begin
      p1_valid <= 1'b0;
    end
  end

  // Capture the taken request; regroup the time stamp and temperature into one extreme word
  always_ff @(posedge clk) begin
    if (s_acc) begin
      p1_mode   <= s_axis_tuser;
      p1_sid    <= in_sid;
      p1_addr   <= in_addr;
      p1_inside <= 32'(in_sid) < 32'(STATIONS);
      p1_sample <= {s_axis_tdata[SID_W +: EXT_W-TEMP_W],
                    s_axis_tdata[SID_W+EXT_W-TEMP_W +: TEMP_W]};
    end
  end

  // Hold the last record write for forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (p1_write) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_write) begin
      fwd_addr <= p1_addr;
      fwd_data <= upd;
    end
  end

  // Output register for read results
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (p1_done && (p1_mode == MODE_READ)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_done && (p1_mode == MODE_READ)) begin
      m_axis_tdata <= {{M_PAD_W{1'b0}}, res.high, res.low, p1_sid};
      m_axis_tuser <= res.valid;
    end
  end

endmodule

FILE: hdl/psx_mem.sv
// Station table: synchronous RAM, one write port, one registered read port.
module psx_mem
  import psx_pkg::*;
#(
  parameter int unsigned DEPTH = STATIONS_DEFAULT,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read returns the old contents on a same-cycle write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/psx_update.sv
// Merge logic: new table word for a record request, result word for a read.
module psx_update
  import psx_pkg::*;
(
  input  entry_t   cur,
  input  request_t req,
  output entry_t   upd,
  output entry_t   res
);

  logic below;
  logic above;

  // Strict compares keep the earliest sample on a tie
  assign below = $signed(req.sample.temp) < $signed(cur.low.temp);
  assign above = $signed(req.sample.temp) > $signed(cur.high.temp);

  // Build the write-back word
  always_comb begin
    upd.valid = 1'b1;
    if (!cur.valid) begin
      upd.low  = req.sample;
      upd.high = req.sample;
    end else begin
      upd.low  = below ? req.sample : cur.low;
      upd.high = above ? req.sample : cur.high;
    end
  end

  // Unseen or out-of-table stations read as zeros
  always_comb begin
    if (req.in_table && cur.valid) begin
      res = cur;
    end else begin
      res = '0;
    end
  end

endmodule

FILE: hdl/psx_checker.sv
// Port-level checks for the temperature extremes tracker, bound to the top.
module psx_checker
  import psx_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic                 m_axis_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Refuse requests at the start of the clearing sweep after reset
  a_clear_sweep: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("request taken during clearing sweep");

  // Unseen stations read as zeros
  a_unseen_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[M_TDATA_W-1:SID_W] == '0)
    else $error("unseen station result not zero");

  // A fresh result follows a taken read request
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready &&
                                   (s_axis_tuser == MODE_READ), 2))
    else $error("result without read request");

endmodule

bind per_station_temperature_extremes psx_checker u_psx_checker (.*);

FILE: dv/tb_per_station_temperature_extremes.sv
// Testbench for the per-station temperature extremes tracker: directed table plus random traffic.
module tb_per_station_temperature_extremes;
  import psx_pkg::*;

  localparam int unsigned NUM_STATIONS    = STATIONS_DEFAULT;
  localparam int unsigned RANDOM_REQUESTS = 1600;
  // Covers the table-clearing sweep after reset with plenty of margin
  localparam int unsigned IDLE_LIMIT      = 5000;
  localparam int unsigned DRAIN_CYCLES    = 8;

  // One readout as it leaves the block
  typedef struct packed {
    logic [SID_W-1:0] station;
    logic             seen;
    extreme_t         low;
    extreme_t         high;
  } readout_t;

  // One stimulus row; a typed readout overrides the tracker model for that read
  typedef struct {
    logic             mode;
    logic [SID_W-1:0] station;
    extreme_t         sample;
    bit               has_typed;
    readout_t         typed;
  } stim_row_t;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;

  per_station_temperature_extremes #(
    .STATIONS(NUM_STATIONS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Tracker model state
  bit        seen_by_station [NUM_STATIONS];
  extreme_t  low_by_station  [NUM_STATIONS];
  extreme_t  high_by_station [NUM_STATIONS];
  readout_t  expected_readouts[$];
  stim_row_t active_row;

  int mismatches       = 0;
  int records_taken    = 0;
  int reads_taken      = 0;
  int readouts_checked = 0;
  int seen_readouts    = 0;
  int idle_cycles      = 0;
  int burst_left       = 0;

  function automatic extreme_t stamp(input int temp, input int month, input int day,
                                     input int hour, input int minute);
    extreme_t e;
    e.temp   = temp[15:0];
    e.month  = month[3:0];
    e.day    = day[4:0];
    e.hour   = hour[4:0];
    e.minute = minute[5:0];
    return e;
  endfunction

  function automatic stim_row_t record_row(input int station, input extreme_t sample);
    stim_row_t r;
    r.mode      = MODE_RECORD;
    r.station   = station[SID_W-1:0];
    r.sample    = sample;
    r.has_typed = 1'b0;
    r.typed     = '0;
    return r;
  endfunction

  function automatic stim_row_t read_row(input int station);
    stim_row_t r;
    r.mode      = MODE_READ;
    r.station   = station[SID_W-1:0];
    r.sample    = '0;
    r.has_typed = 1'b0;
    r.typed     = '0;
    return r;
  endfunction

  function automatic stim_row_t read_row_typed(input int station, input logic seen,
                                               input extreme_t low, input extreme_t high);
    stim_row_t r;
    r               = read_row(station);
    r.has_typed     = 1'b1;
    r.typed.station = station[SID_W-1:0];
    r.typed.seen    = seen;
    r.typed.low     = low;
    r.typed.high    = high;
    return r;
  endfunction

  // Update the extremes table for one accepted request; queue the readout of a read
  function automatic void apply_request(input stim_row_t row);
    readout_t r;
    if (row.mode == MODE_RECORD) begin
      records_taken++;
      if (row.station < NUM_STATIONS) begin
        if (!seen_by_station[row.station]) begin
          seen_by_station[row.station] = 1'b1;
          low_by_station[row.station]  = row.sample;
          high_by_station[row.station] = row.sample;
        end else begin
          // Strict compare: on a tie the earlier sample stays
          if ($signed(row.sample.temp) > $signed(high_by_station[row.station].temp))
            high_by_station[row.station] = row.sample;
          if ($signed(row.sample.temp) < $signed(low_by_station[row.station].temp))
            low_by_station[row.station] = row.sample;
        end
      end
    end else begin
      reads_taken++;
      r         = '0;
      r.station = row.station;
      if (row.station < NUM_STATIONS && seen_by_station[row.station]) begin
        r.seen = 1'b1;
        r.low  = low_by_station[row.station];
        r.high = high_by_station[row.station];
      end
      expected_readouts.push_back(row.has_typed ? row.typed : r);
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_extreme(input string prefix, input extreme_t want,
                                        input extreme_t got);
    check_field({prefix, "_temp"}, int'($signed(want.temp)), int'($signed(got.temp)));
    check_field({prefix, "_month"}, int'(want.month), int'(got.month));
    check_field({prefix, "_day"}, int'(want.day), int'(got.day));
    check_field({prefix, "_hour"}, int'(want.hour), int'(got.hour));
    check_field({prefix, "_minute"}, int'(want.minute), int'(got.minute));
  endfunction

  // Track both handshakes at the rising edge: model first, then compare results
  always @(posedge clk) begin : bus_monitor
    readout_t got;
    readout_t want;
    bit       moved;
    moved = 1'b0;
    if (s_axis_tvalid && s_axis_tready) begin
      apply_request(active_row);
      moved = 1'b1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      moved       = 1'b1;
      got.station = m_axis_tdata[SID_W-1:0];
      got.seen    = m_axis_tuser;
      got.low     = m_axis_tdata[SID_W +: EXT_W];
      got.high    = m_axis_tdata[SID_W+EXT_W +: EXT_W];
      if (expected_readouts.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected readout for station %0d", $time, got.station);
      end else begin
        want = expected_readouts.pop_front();
        readouts_checked++;
        if (got.seen)
          seen_readouts++;
        check_field("out_station", int'(want.station), int'(got.station));
        check_field("seen", int'(want.seen), int'(got.seen));
        check_extreme("low", want.low, got.low);
        check_extreme("high", want.high, got.high);
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: nothing accepted for %0d cycles, %0d readouts outstanding",
               $time, idle_cycles, expected_readouts.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drive one request and hold it until taken; pause between bursts
  task automatic send_row(input stim_row_t row);
    int gap;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{S_PAD_W{1'b0}}, row.sample.temp, row.sample.minute,
                      row.sample.hour, row.sample.day, row.sample.month, row.station};
    s_axis_tuser  <= row.mode;
    active_row    <= row;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Stall the result side in runs, with occasional long open stretches
  initial begin : result_backpressure
    int run;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
      repeat (run) begin
        @(negedge clk);
        m_axis_tready <= 1'b1;
      end
      run = $urandom_range(1, 5);
      repeat (run) begin
        @(negedge clk);
        m_axis_tready <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    stim_row_t directed[$];
    stim_row_t row;
    extreme_t  coldest;
    extreme_t  hottest;
    extreme_t  masked;
    int        sid;
    int        last_sid;
    int        pick;
    int        temp;
    int        month;
    int        day;
    int        hour;
    int        minute;

    coldest = stamp(-32768, 12, 31, 23, 59);
    hottest = stamp(32767, 1, 1, 0, 0);
    masked  = stamp(0, 15, 0, 31, 63);

    // Directed table: unseen reads, extremes, ties, raw time fields, back-to-back updates
    directed.push_back(read_row_typed(0, 1'b0, '0, '0));
    directed.push_back(read_row_typed(NUM_STATIONS - 1, 1'b0, '0, '0));
    directed.push_back(record_row(0, coldest));
    directed.push_back(read_row_typed(0, 1'b1, coldest, coldest));
    directed.push_back(record_row(0, hottest));
    directed.push_back(read_row_typed(0, 1'b1, coldest, hottest));
    directed.push_back(record_row(0, stamp(32767, 6, 15, 12, 30)));
    directed.push_back(record_row(0, stamp(-32768, 7, 4, 1, 2)));
    directed.push_back(read_row_typed(0, 1'b1, coldest, hottest));
    directed.push_back(record_row(0, stamp(0, 3, 3, 3, 3)));
    directed.push_back(read_row(0));
    directed.push_back(record_row(NUM_STATIONS - 1, masked));
    directed.push_back(read_row_typed(NUM_STATIONS - 1, 1'b1, masked, masked));
    directed.push_back(record_row(5, stamp(100, 3, 3, 3, 3)));
    directed.push_back(record_row(5, stamp(99, 4, 4, 4, 4)));
    directed.push_back(record_row(5, stamp(101, 5, 5, 5, 5)));
    directed.push_back(read_row(5));
    directed.push_back(record_row(512, stamp(-1, 8, 16, 16, 32)));
    directed.push_back(record_row(512, stamp(0, 9, 17, 17, 33)));
    directed.push_back(read_row(512));
    directed.push_back(read_row_typed(1, 1'b0, '0, '0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_row(directed[i]);

    // Random traffic: mostly a small pool of hot stations so extremes keep moving
    last_sid = 0;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        sid = $urandom_range(0, 15);
      else if (pick < 70)
        sid = last_sid;
      else if (pick < 78)
        sid = ($urandom_range(0, 1) != 0) ? NUM_STATIONS - 1 : 0;
      else
        sid = $urandom_range(0, NUM_STATIONS - 1);
      last_sid = sid;

      pick = $urandom_range(0, 99);
      if (pick < 35)
        temp = int'($urandom_range(0, 65535)) - 32768;
      else if (pick < 65)
        temp = int'($urandom_range(0, 16)) - 8;
      else if (pick < 85)
        temp = ($urandom_range(0, 1) != 0) ? int'($signed(low_by_station[sid].temp))
                                           : int'($signed(high_by_station[sid].temp));
      else begin
        case ($urandom_range(0, 3))
          0:       temp = -32768;
          1:       temp = 32767;
          2:       temp = -1;
          default: temp = 0;
        endcase
      end

      if ($urandom_range(0, 9) == 0) begin
        month  = $urandom_range(0, 15);
        day    = $urandom_range(0, 31);
        hour   = $urandom_range(0, 31);
        minute = $urandom_range(0, 63);
      end else begin
        month  = $urandom_range(1, 12);
        day    = $urandom_range(1, 31);
        hour   = $urandom_range(0, 23);
        minute = $urandom_range(0, 59);
      end

      if ($urandom_range(0, 99) < 30)
        row = read_row(sid);
      else
        row = record_row(sid, stamp(temp, month, day, hour, minute));
      send_row(row);
    end

    // Drop valid and drain the outstanding readouts
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_readouts.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests: %0d records and %0d reads.",
             records_taken + reads_taken, records_taken, reads_taken);
    $display("Checked %0d readouts, %0d of seen stations; %0d field mismatches.",
             readouts_checked, seen_readouts, mismatches);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
